[hdl/cdwe_pkg.sv]
// Shared widths, constants and channel types of the clock drift window estimator.
package cdwe_pkg;

    localparam int TS_W    = 40;
    localparam int WALL_W  = 32;
    localparam int CC_W    = 21;
    localparam int OC_W    = 16;
    localparam int LEN_W   = 10;
    localparam int SEQ_W   = 8;
    localparam int TPM_W   = 26;
    localparam int CI_W    = 17;
    localparam int CO_W    = 19;
    localparam int CU_W    = 32;
    localparam int E_W     = 58;
    localparam int DIV_W   = 64;
    localparam int QUOT_W  = 18;
    localparam int NB_W    = 5;
    localparam int FRAC_W  = 27;
    localparam int Q0_W    = 5;
    localparam int DIGIT_W = 4;
    localparam int DIG_W   = 3;
    localparam int DIGITS  = 8;

    // Job sums are sized for the largest supported window of 256 frames.
    localparam int CSUM_W = 29;
    localparam int OSUM_W = 24;

    localparam int JOBQ_DEPTH = 2;

    localparam int CARRIER_SHIFT = 31;
    localparam int OFFSET_SHIFT  = 4;
    localparam int SAT_QUOT      = 22;

    localparam logic [TPM_W-1:0]  TPM_RESET   = 26'd63897600;
    localparam logic [FRAC_W-1:0] CENTI_SCALE = 27'd100000000;
    localparam logic [6:0]        PCT_SCALE   = 7'd100;
    localparam logic [SEQ_W-1:0]  SEQ_NONE    = 8'hFF;
    localparam logic [LEN_W-1:0]  MIN_LEN     = 10'd3;
    localparam logic [CU_W-1:0]   CU_MAX      = 32'h7FFF_FFFF;
    localparam logic [CU_W-1:0]   CU_MIN      = 32'h8000_0000;

    typedef struct packed {
        logic [SEQ_W-1:0]         seq;
        logic signed [CSUM_W-1:0] csum;
        logic signed [OSUM_W-1:0] osum;
        logic [TS_W-1:0]          ticks;
        logic [WALL_W-1:0]        ms;
    } t_job;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den_top;
        logic [NB_W-1:0]   nbits;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [DIV_W-1:0]  rem;
    } t_div_rsp;

endpackage

[hdl/cdwe_front.sv]
// Frame intake: filters bad frames, holds the reference and the window sums, issues jobs.
module cdwe_front import cdwe_pkg::*; #(
    parameter int WINDOW_PACKETS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_frame_good,
    input  logic [TS_W-1:0]         i_rx_timestamp,
    input  logic [WALL_W-1:0]       i_wall_ms,
    input  logic signed [CC_W-1:0]  i_carrier_count,
    input  logic signed [OC_W-1:0]  i_offset_count,
    input  logic [LEN_W-1:0]        i_frame_length,
    input  logic [SEQ_W-1:0]        i_payload_seq_byte,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_job                    o_q_job
);

    localparam int CNT_W = $clog2(WINDOW_PACKETS);
    localparam int CS_W  = CC_W + CNT_W;
    localparam int OS_W  = OC_W + CNT_W;

    logic                   r_have_ref;
    logic [TS_W-1:0]        r_ref_ts;
    logic [WALL_W-1:0]      r_ref_wall;
    logic signed [CS_W-1:0] r_csum;
    logic signed [OS_W-1:0] r_osum;
    logic [CNT_W-1:0]       r_count;

    logic                   good;
    logic                   last;
    logic [TS_W-1:0]        ref_ts;
    logic [WALL_W-1:0]      ref_wall;
    logic signed [CS_W-1:0] n_csum;
    logic signed [OS_W-1:0] n_osum;

    always_comb begin
        good     = i_push && !i_q_full && i_frame_good;
        last     = (r_count == CNT_W'(WINDOW_PACKETS - 1));
        ref_ts   = r_have_ref ? r_ref_ts : i_rx_timestamp;
        ref_wall = r_have_ref ? r_ref_wall : i_wall_ms;
        n_csum   = r_csum + CS_W'(i_carrier_count);
        n_osum   = r_osum + OS_W'(i_offset_count);

        o_q_push      = good && last;
        o_q_job.seq   = (i_frame_length >= MIN_LEN) ? i_payload_seq_byte : SEQ_NONE;
        o_q_job.csum  = CSUM_W'(n_csum);
        o_q_job.osum  = OSUM_W'(n_osum);
        o_q_job.ticks = i_rx_timestamp - ref_ts;
        o_q_job.ms    = i_wall_ms - ref_wall;
    end

    assign o_full = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_ref <= 1'b0;
            r_ref_ts   <= '0;
            r_ref_wall <= '0;
            r_csum     <= '0;
            r_osum     <= '0;
            r_count    <= '0;
        end else if (good) begin
            r_have_ref <= 1'b1;
            r_ref_ts   <= ref_ts;
            r_ref_wall <= ref_wall;
            if (last) begin
                r_csum  <= '0;
                r_osum  <= '0;
                r_count <= '0;
            end else begin
                r_csum  <= n_csum;
                r_osum  <= n_osum;
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

[hdl/cdwe_jobq.sv]
// Short job queue between the frame intake and the arithmetic back end.
module cdwe_jobq import cdwe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    t_job             r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(JOBQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

endmodule

[hdl/cdwe_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all window divisions.
module cdwe_div import cdwe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [NB_W-1:0]   r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_quot;

    logic ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.nbits;
            r_rem  <= i_req.num;
            r_dsh  <= i_req.den_top;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? r_rem - r_dsh : r_rem;
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == NB_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    a_busy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with no steps left");

endmodule

[hdl/cdwe_back.sv]
// Window arithmetic: means of both offsets and the cumulative drift, plus the result register.
module cdwe_back import cdwe_pkg::*; #(
    parameter int WINDOW_PACKETS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_job                   i_job,
    input  logic                   i_job_empty,
    output logic                   o_job_pop,
    input  logic [TPM_W-1:0]       i_tpm,
    output t_div_req               o_div_req,
    input  t_div_rsp               i_div_rsp,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [SEQ_W-1:0]       o_sequence_res,
    output logic signed [CI_W-1:0] o_carrier_ppm_centi,
    output logic signed [CO_W-1:0] o_offset_ppm_centi,
    output logic signed [CU_W-1:0] o_cumulative_ppm_centi,
    output logic                   o_cumulative_valid
);

    localparam int PC_W  = CSUM_W + FRAC_W;
    localparam int PO_W  = OSUM_W + 7;
    localparam int E22_W = E_W + 5;
    localparam logic [DIV_W-1:0] WIN_DEN = DIV_W'(WINDOW_PACKETS) << (QUOT_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV_C,
        S_DIV_O,
        S_Q0,
        S_DIG,
        S_FIN,
        S_OUT
    } t_state;

    t_state                 r_state;
    t_job                   r_job;
    logic [PC_W-1:0]        r_prod_c;
    logic [PO_W-1:0]        r_prod_o;
    logic [E_W-1:0]         r_e;
    logic [E_W-1:0]         r_d;
    logic                   r_neg_d;
    logic [E22_W-1:0]       r_e22;
    logic signed [CI_W-1:0] r_ci;
    logic signed [CO_W-1:0] r_co;
    logic [Q0_W-1:0]        r_q0;
    logic [FRAC_W-1:0]      r_frac;
    logic [DIG_W-1:0]       r_dig;
    logic [CU_W-1:0]        r_cu;
    logic                   r_cv;
    logic                   r_o_vld;
    logic [SEQ_W-1:0]       r_o_seq;
    logic signed [CI_W-1:0] r_o_ci;
    logic signed [CO_W-1:0] r_o_co;
    logic [CU_W-1:0]        r_o_cu;
    logic                   r_o_cv;

    logic [CSUM_W-1:0]      mag_c;
    logic [OSUM_W-1:0]      mag_o;
    logic [E_W-1:0]         ticks;
    logic signed [CI_W-1:0] q_ci;
    logic signed [CO_W-1:0] q_co;
    logic [DIV_W-1:0]       rem10;
    logic [CU_W-1:0]        q_cu;
    logic                   sat;
    logic                   load_out;

    always_comb begin
        mag_c    = r_job.csum[CSUM_W-1] ? CSUM_W'(-r_job.csum) : CSUM_W'(r_job.csum);
        mag_o    = r_job.osum[OSUM_W-1] ? OSUM_W'(-r_job.osum) : OSUM_W'(r_job.osum);
        ticks    = E_W'(r_job.ticks);
        q_ci     = CI_W'(i_div_rsp.quot);
        q_co     = CO_W'(i_div_rsp.quot);
        rem10    = (i_div_rsp.rem << 3) + (i_div_rsp.rem << 1);
        q_cu     = CU_W'(r_q0) * CU_W'(CENTI_SCALE) + CU_W'(r_frac);
        sat      = (E22_W'(r_d) >= r_e22);
        load_out = (r_state == S_OUT) && (!r_o_vld || i_pop);
    end

    always_comb begin
        o_div_req.start   = 1'b0;
        o_div_req.num     = '0;
        o_div_req.den_top = WIN_DEN;
        o_div_req.nbits   = NB_W'(QUOT_W);
        unique case (r_state)
            S_PREP: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DIV_W'(r_prod_c >> CARRIER_SHIFT);
            end
            S_DIV_C: begin
                o_div_req.start = i_div_rsp.done;
                o_div_req.num   = DIV_W'(r_prod_o >> OFFSET_SHIFT);
            end
            S_DIV_O: begin
                o_div_req.start   = i_div_rsp.done && (r_e != '0) && !sat;
                o_div_req.num     = DIV_W'(r_d);
                o_div_req.den_top = DIV_W'(r_e) << 4;
                o_div_req.nbits   = NB_W'(Q0_W);
            end
            S_Q0, S_DIG: begin
                o_div_req.start   = i_div_rsp.done &&
                                    !(r_state == S_DIG && r_dig == DIG_W'(DIGITS - 1));
                o_div_req.num     = rem10;
                o_div_req.den_top = DIV_W'(r_e) << 3;
                o_div_req.nbits   = NB_W'(DIGIT_W);
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
        end else begin
            if (i_pop && r_o_vld) begin
                r_o_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod_c <= PC_W'(mag_c) * PC_W'(CENTI_SCALE);
                    r_prod_o <= PO_W'(mag_o) * PO_W'(PCT_SCALE);
                    r_e      <= E_W'(r_job.ms) * E_W'(i_tpm);
                    r_state  <= S_PREP;
                end
                S_PREP: begin
                    r_neg_d <= (ticks < r_e);
                    r_d     <= (ticks < r_e) ? r_e - ticks : ticks - r_e;
                    r_e22   <= (E22_W'(r_e) << 4) + (E22_W'(r_e) << 2) + (E22_W'(r_e) << 1);
                    r_state <= S_DIV_C;
                end
                S_DIV_C: begin
                    if (i_div_rsp.done) begin
                        r_ci    <= r_job.csum[CSUM_W-1] ? q_ci : -q_ci;
                        r_state <= S_DIV_O;
                    end
                end
                S_DIV_O: begin
                    if (i_div_rsp.done) begin
                        r_co <= r_job.osum[OSUM_W-1] ? -q_co : q_co;
                        if (r_e == '0) begin
                            r_cu    <= '0;
                            r_cv    <= 1'b0;
                            r_state <= S_OUT;
                        end else if (sat) begin
                            r_cu    <= r_neg_d ? CU_MIN : CU_MAX;
                            r_cv    <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_Q0;
                        end
                    end
                end
                S_Q0: begin
                    if (i_div_rsp.done) begin
                        r_q0    <= i_div_rsp.quot[Q0_W-1:0];
                        r_frac  <= '0;
                        r_dig   <= '0;
                        r_state <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (i_div_rsp.done) begin
                        r_frac <= (r_frac << 3) + (r_frac << 1) +
                                  FRAC_W'(i_div_rsp.quot[DIGIT_W-1:0]);
                        if (r_dig == DIG_W'(DIGITS - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_dig <= r_dig + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (r_neg_d) begin
                        r_cu <= (q_cu >= CU_MIN) ? CU_MIN : ~q_cu + 1'b1;
                    end else begin
                        r_cu <= (q_cu >= CU_MIN) ? CU_MAX : q_cu;
                    end
                    r_cv    <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) begin
                        r_o_vld <= 1'b1;
                        r_o_seq <= r_job.seq;
                        r_o_ci  <= r_ci;
                        r_o_co  <= r_co;
                        r_o_cu  <= r_cu;
                        r_o_cv  <= r_cv;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty                = !r_o_vld;
    assign o_sequence_res         = r_o_seq;
    assign o_carrier_ppm_centi    = r_o_ci;
    assign o_offset_ppm_centi     = r_o_co;
    assign o_cumulative_ppm_centi = CU_W'(r_o_cu);
    assign o_cumulative_valid     = r_o_cv;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_vld && !i_pop) |=> (r_state == S_OUT))
        else $error("result register overwritten before it was taken");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divider started while still busy");

endmodule

[hdl/clock_drift_window_estimator.sv]
// Top level of the clock drift window estimator: register, intake, job queue, divider and back end.
// Flow: one frame beat is taken per cycle while full is low. A window result passes through
// the job queue and the back end's multiply, divide and digit steps, skipping the digit steps
// when the drift saturates or no wall time elapsed. The back end works on one window at a time
// on the shared restoring divider, which yields one quotient bit per cycle.
// Reset: clears the reference, the window sums and count, the job queue and the result
// register, and sets ticks_per_ms to 63897600; no clearing pass is needed.
module clock_drift_window_estimator import cdwe_pkg::*; #(
    parameter int WINDOW_PACKETS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_frame_good,
    input  logic [TS_W-1:0]        i_rx_timestamp,
    input  logic [WALL_W-1:0]      i_wall_ms,
    input  logic signed [CC_W-1:0] i_carrier_count,
    input  logic signed [OC_W-1:0] i_offset_count,
    input  logic [LEN_W-1:0]       i_frame_length,
    input  logic [SEQ_W-1:0]       i_payload_seq_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [SEQ_W-1:0]       o_sequence_res,
    output logic signed [CI_W-1:0] o_carrier_ppm_centi,
    output logic signed [CO_W-1:0] o_offset_ppm_centi,
    output logic signed [CU_W-1:0] o_cumulative_ppm_centi,
    output logic                   o_cumulative_valid,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [TPM_W-1:0]       i_cfg_data
);

    logic [TPM_W-1:0] r_tpm;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_job     q_in;
    t_job     q_out;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm <= TPM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tpm <= i_cfg_data;
        end
    end

    cdwe_front #(
        .WINDOW_PACKETS (WINDOW_PACKETS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_frame_good       (i_frame_good),
        .i_rx_timestamp     (i_rx_timestamp),
        .i_wall_ms          (i_wall_ms),
        .i_carrier_count    (i_carrier_count),
        .i_offset_count     (i_offset_count),
        .i_frame_length     (i_frame_length),
        .i_payload_seq_byte (i_payload_seq_byte),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_job            (q_in)
    );

    cdwe_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    cdwe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    cdwe_back #(
        .WINDOW_PACKETS (WINDOW_PACKETS)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_job                  (q_out),
        .i_job_empty            (q_empty),
        .o_job_pop              (q_pop),
        .i_tpm                  (r_tpm),
        .o_div_req              (div_req),
        .i_div_rsp              (div_rsp),
        .i_pop                  (pop),
        .o_empty                (empty),
        .o_sequence_res         (o_sequence_res),
        .o_carrier_ppm_centi    (o_carrier_ppm_centi),
        .o_offset_ppm_centi     (o_offset_ppm_centi),
        .o_cumulative_ppm_centi (o_cumulative_ppm_centi),
        .o_cumulative_valid     (o_cumulative_valid)
    );

endmodule
